>>> sv/wgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Shared constants, item payloads and the control broadcast to the cells.
// ----------------------------------------------------------------------------
package wgm_pkg;

   localparam int MAX_PATTERN = 128;
   localparam int NUM_POS     = MAX_PATTERN + 1;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int CHAR_W      = 8;

   localparam logic [CHAR_W-1:0] WILD_ONE = CHAR_W'(63);
   localparam logic [CHAR_W-1:0] WILD_RUN = CHAR_W'(42);

   typedef enum logic {
      CMD_PATTERN = 1'b0,
      CMD_TEXT    = 1'b1
   } wgm_cmd_type;

   typedef struct packed {
      wgm_cmd_type       cmd;
      logic              first_char;
      logic              last_char;
      logic [CHAR_W-1:0] char_code;
   } wgm_req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } wgm_rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic              step;
      logic              restart;
      logic              clear;
      logic              load_en;
      logic [LEN_W-1:0]  load_idx;
      logic [CHAR_W-1:0] ch;
   } wgm_bcast_type;

   // Per-cell view of the pattern length.
   typedef struct packed {
      logic live;
      logic reach;
      logic load;
   } wgm_slot_type;

endpackage
`default_nettype wire

>>> sv/wgm_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher channels
// Valid/ready channels for character items and match results.
// ----------------------------------------------------------------------------
interface wgm_req_if;
   logic                valid;
   logic                ready;
   wgm_pkg::wgm_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
   modport mon    (input valid, input payload, input ready);
endinterface

interface wgm_rsp_if;
   logic                valid;
   logic                ready;
   wgm_pkg::wgm_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
   modport mon    (input valid, input payload, input ready);
endinterface
`default_nettype wire

>>> sv/wgm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher cell
// Holds one pattern character and the active bit of its position.
// ----------------------------------------------------------------------------
module wgm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wgm_pkg::wgm_bcast_type bcast,
   input  wgm_pkg::wgm_slot_type  slot,
   input  logic                  fwd_in,
   input  logic                  spread_in,
   input  logic                  lead_in,
   output logic                  fwd_out,
   output logic                  spread_out,
   output logic                  lead_out,
   output logic                  act_out
);
   import wgm_pkg::*;

   logic              act_ff, act_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              lead_ff, lead_in_nx;
   logic              star, one, src, pre, nxt;

   always_comb begin
      star = (char_ff == WILD_RUN);
      one  = (char_ff == WILD_ONE);
      // On a text restart the source vector is position 0 plus every
      // position behind a run of leading stars.
      src  = bcast.restart ? (lead_in & slot.reach) : act_ff;
      fwd_out = src & slot.live & ~star & (one | (char_ff == bcast.ch));
      pre  = (src & slot.live & star) | fwd_in;
      // Empty-run matches ripple forward through consecutive stars.
      nxt  = pre | spread_in;
      spread_out = nxt & slot.live & star;
      lead_out = lead_ff;
      act_out  = act_ff;

      act_in = act_ff;
      if (bcast.clear) begin
         act_in = 1'b0;
      end else if (bcast.step) begin
         act_in = nxt;
      end
      char_in    = slot.load ? bcast.ch : char_ff;
      lead_in_nx = slot.load ? (lead_in & (bcast.ch == WILD_RUN)) : lead_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      lead_ff <= lead_in_nx;
   end

endmodule
`default_nettype wire

>>> sv/wgm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher control
// Pattern length, overflow flag, item handshake and the result register.
// ----------------------------------------------------------------------------
module wgm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   wgm_req_if.sink                req,
   wgm_rsp_if.source              rsp,
   input  logic                   hit,
   output wgm_pkg::wgm_bcast_type bcast,
   output logic [wgm_pkg::LEN_W-1:0] len
);
   import wgm_pkg::*;

   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             povf_ff, povf_in;
   logic             accept, is_text, full, out_free;
   logic [LEN_W-1:0] widx;

   assign req.ready   = ~pend_ff;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = '{matched: matched_ff, pattern_overflow: povf_ff};

   // Length is needed by the top level for the per-cell slot decode.
   assign len = len_ff;

   always_comb begin
      accept   = req.valid & req.ready;
      is_text  = (req.payload.cmd == CMD_TEXT);
      widx     = req.payload.first_char ? '0 : len_ff;
      full     = (widx == LEN_W'(MAX_PATTERN));
      out_free = ~rsp_valid_ff | rsp.ready;

      bcast.step     = accept & is_text;
      bcast.restart  = accept & is_text & req.payload.first_char;
      bcast.clear    = accept & ~is_text & req.payload.first_char;
      bcast.load_en  = accept & ~is_text & ~full;
      bcast.load_idx = widx;
      bcast.ch       = req.payload.char_code;

      len_in = len_ff;
      ovf_in = ovf_ff;
      if (accept && !is_text) begin
         len_in = full ? widx : widx + LEN_W'(1);
         ovf_in = (req.payload.first_char ? 1'b0 : ovf_ff) | full;
      end

      // The final match bit is read from the cells after the last text item,
      // once the result register is free, while no new item is taken.
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      matched_in   = matched_ff;
      povf_in      = povf_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff && out_free) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         matched_in   = hit;
         povf_in      = ovf_ff;
      end
      if (accept && is_text && req.payload.last_char) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      povf_ff    <= povf_in;
   end

endmodule
`default_nettype wire

>>> sv/wildcard_glob_matcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher core
// Pattern characters load into a row of cells; text characters step the
// active-position vector in the cells; the one at the pattern length reports.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req.valid / req.ready  | cmd, first_char, last_char, char_code
//  rsp     | out | rsp.valid / rsp.ready  | matched, pattern_overflow
//
//  A pattern item, or a text item without the last mark, leaves the input
//  ready for the next item. After a text item with the last mark, a read
//  cycle reads the active bit at the pattern length into the result
//  register. Star runs ripple through the cell row within the stepping
//  cycle; the pattern store needs no clearing pass after reset.
//  The read cycle lasts until an earlier result has been taken, and no item
//  is accepted during it; a waiting result holds up nothing else.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_core (
   input  logic      clock,
   input  logic      reset,
   wgm_req_if.sink   req,
   wgm_rsp_if.source rsp
);
   import wgm_pkg::*;

   wgm_bcast_type    bcast;
   logic [LEN_W-1:0] len;
   wgm_slot_type     slot [NUM_POS];
   logic             fwd    [NUM_POS+1];
   logic             spread [NUM_POS+1];
   logic             lead   [NUM_POS+1];
   logic [NUM_POS-1:0] act_vec, at_len_vec;
   logic             hit;

   wgm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .hit   (hit),
      .bcast (bcast),
      .len   (len)
   );

   assign fwd[0]    = 1'b0;
   assign spread[0] = 1'b0;
   assign lead[0]   = 1'b1;
   assign hit       = |(act_vec & at_len_vec);

   for (genvar p = 0; p < NUM_POS; p++) begin : g_cell
      always_comb begin
         slot[p].live  = (LEN_W'(p) < len);
         slot[p].reach = (LEN_W'(p) <= len);
         slot[p].load  = bcast.load_en & (bcast.load_idx == LEN_W'(p));
      end

      assign at_len_vec[p] = (LEN_W'(p) == len);

      wgm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .bcast      (bcast),
         .slot       (slot[p]),
         .fwd_in     (fwd[p]),
         .spread_in  (spread[p]),
         .lead_in    (lead[p]),
         .fwd_out    (fwd[p+1]),
         .spread_out (spread[p+1]),
         .lead_out   (lead[p+1]),
         .act_out    (act_vec[p])
      );
   end

endmodule
`default_nettype wire

>>> sv/wgm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher checker
// Port-level checks on result timing and the handshake.
// ----------------------------------------------------------------------------
module wgm_checker (
   input logic  clock,
   input logic  reset,
   wgm_req_if.sink   req,
   wgm_rsp_if.source rsp
);
   import wgm_pkg::*;

   logic last_text;

   assign last_text = req.valid & req.ready & (req.payload.cmd == CMD_TEXT)
                      & req.payload.last_char;

   // The cycle after a last text item is spent reading the match bit.
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      last_text |=> !req.ready)
      else $error("input ready after a last text item");

   // A result only appears after a read cycle.
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(!req.ready))
      else $error("result without a read cycle");

   // Pattern items never produce a result.
   a_pattern_silent: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.payload.cmd == CMD_PATTERN && !rsp.valid)
      |=> !rsp.valid)
      else $error("result caused by a pattern item");

   // The read cycle ends as soon as the result register is free.
   a_stall_short: assert property (@(posedge clock) disable iff (reset)
      (!req.ready && (!rsp.valid || rsp.ready)) |=> req.ready)
      else $error("input stalled with a free result register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)))
      else $error("result dropped or changed while stalled");

endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);
`default_nettype wire

>>> bench/wgm_match_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard glob matcher result checker
// Watches both channels, tracks the pattern store and the active-position
// vector, and compares every result item against the predicted verdict.
// ----------------------------------------------------------------------------
module wgm_match_checker
   import wgm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   wgm_req_if.mon req,
   wgm_rsp_if.mon rsp,
   output int     mismatch_count,
   output int     results_due
);

   logic [CHAR_W-1:0] pat_mem [MAX_PATTERN];
   int                pat_len;
   bit                pat_overflow;
   bit [NUM_POS-1:0]  live_pos;
   wgm_rsp_type       verdict_q [$];
   int                err_tally;

   initial begin
      err_tally      = 0;
      mismatch_count = 0;
      results_due    = 0;
   end

   // A live star position also makes the position after it live.
   function automatic bit [NUM_POS-1:0] close_stars(bit [NUM_POS-1:0] vec);
      for (int p = 0; p < pat_len; p++) begin
         if (vec[p] && pat_mem[p] == WILD_RUN) begin
            vec[p+1] = 1'b1;
         end
      end
      return vec;
   endfunction

   function automatic bit [NUM_POS-1:0] advance_text(bit [NUM_POS-1:0] vec,
                                                      logic [CHAR_W-1:0] ch);
      bit [NUM_POS-1:0] nxt;
      nxt = '0;
      for (int p = 0; p < pat_len; p++) begin
         if (vec[p]) begin
            if (pat_mem[p] == WILD_RUN) begin
               nxt[p] = 1'b1;
            end else if (pat_mem[p] == WILD_ONE || pat_mem[p] == ch) begin
               nxt[p+1] = 1'b1;
            end
         end
      end
      return close_stars(nxt);
   endfunction

   task automatic flag_mismatch(string what, wgm_rsp_type want, wgm_rsp_type got);
      err_tally++;
      if (err_tally <= 10) begin
         $display("%0t: %s: expected matched=%b overflow=%b, got matched=%b overflow=%b",
                  $realtime, what, want.matched, want.pattern_overflow,
                  got.matched, got.pattern_overflow);
      end
   endtask

   always @(posedge clock) begin
      wgm_rsp_type want;
      wgm_req_type item;
      if (reset) begin
         pat_len      = 0;
         pat_overflow = 1'b0;
         live_pos     = '0;
         verdict_q.delete();
      end else begin
         // A result can never belong to an item accepted at the same edge.
         if (rsp.valid && rsp.ready) begin
            if (verdict_q.size() == 0) begin
               flag_mismatch("result with none expected", '0, rsp.payload);
            end else begin
               want = verdict_q.pop_front();
               if (rsp.payload.matched !== want.matched ||
                   rsp.payload.pattern_overflow !== want.pattern_overflow) begin
                  flag_mismatch("wrong result", want, rsp.payload);
               end
            end
         end
         if (req.valid && req.ready) begin
            item = req.payload;
            if (item.cmd == CMD_PATTERN) begin
               if (item.first_char) begin
                  pat_len      = 0;
                  pat_overflow = 1'b0;
                  live_pos     = '0;
               end
               if (pat_len < MAX_PATTERN) begin
                  pat_mem[pat_len] = item.char_code;
                  pat_len++;
               end else begin
                  pat_overflow = 1'b1;
               end
            end else begin
               if (item.first_char) begin
                  live_pos    = '0;
                  live_pos[0] = 1'b1;
                  live_pos    = close_stars(live_pos);
               end
               live_pos = advance_text(live_pos, item.char_code);
               if (item.last_char) begin
                  want.matched          = live_pos[pat_len];
                  want.pattern_overflow = pat_overflow;
                  verdict_q.push_back(want);
               end
            end
         end
      end
      mismatch_count <= err_tally;
      results_due    <= verdict_q.size();
   end

endmodule

>>> bench/tb_wildcard_glob_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard glob matcher testbench
// Loads patterns and streams texts through the core: a directed opening,
// then random pattern/text sequences with noise under three flow-control
// regimes, including a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_wildcard_glob_matcher_core;
   import wgm_pkg::*;

   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_CYCLES     = 300;
   localparam int ITEMS_PER_PHASE = 540;

   typedef logic [CHAR_W-1:0] char_q_type [$];

   logic clock;
   logic reset;
   int   mismatch_count;
   int   results_due;
   int   send_gap_pct;
   int   recv_gap_pct;
   int   holds_asked;
   int   holds_done;
   int   items_sent;
   int   quiet_cycles;

   wgm_req_if req_ch ();
   wgm_rsp_if rsp_ch ();

   wildcard_glob_matcher_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   wgm_match_checker match_chk (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: random back-pressure, plus long hold-offs on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CHAR_W-1:0] pick_letter();
      if ($urandom_range(9) == 0) begin
         return CHAR_W'($urandom_range(255));
      end
      return CHAR_W'(8'h61 + $urandom_range(3));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_pattern_char();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 25) begin
         return WILD_RUN;
      end else if (roll < 45) begin
         return WILD_ONE;
      end
      return pick_letter();
   endfunction

   function automatic char_q_type make_pattern();
      char_q_type pat;
      int         len;
      len = ($urandom_range(99) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 10);
      repeat (len) pat.push_back(pick_pattern_char());
      return pat;
   endfunction

   // Expands the wildcards into a text that matches, then sometimes breaks it.
   function automatic char_q_type text_for(char_q_type pat);
      char_q_type txt;
      int         pos;
      foreach (pat[i]) begin
         if (pat[i] == WILD_RUN) begin
            repeat ($urandom_range(3)) txt.push_back(pick_letter());
         end else if (pat[i] == WILD_ONE) begin
            txt.push_back(CHAR_W'($urandom_range(255)));
         end else begin
            txt.push_back(pat[i]);
         end
      end
      if ($urandom_range(99) < 30 && txt.size() > 0) begin
         pos = $urandom_range(txt.size() - 1);
         case ($urandom_range(2))
            0: begin
               txt[pos] = pick_letter();
            end
            1: begin
               txt.delete(pos);
            end
            default: begin
               txt.insert(pos, pick_letter());
            end
         endcase
      end
      if (txt.size() == 0) begin
         txt.push_back(pick_letter());
      end
      return txt;
   endfunction

   task automatic offer(input wgm_cmd_type kind, input logic head, input logic tail,
                        input logic [CHAR_W-1:0] code);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= '{cmd: kind, first_char: head, last_char: tail, char_code: code};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // A pattern may carry stray last marks; they must have no effect.
   task automatic offer_pattern(input char_q_type pat);
      int n;
      n = pat.size();
      for (int i = 0; i < n; i++) begin
         offer(CMD_PATTERN, i == 0, (i == n - 1) || ($urandom_range(9) == 0), pat[i]);
      end
   endtask

   // Optionally grows the pattern after the first text item.
   task automatic offer_text(input char_q_type txt, input bit grow_pattern);
      int n;
      n = txt.size();
      for (int i = 0; i < n; i++) begin
         offer(CMD_TEXT, i == 0, i == n - 1, txt[i]);
         if (grow_pattern && i == 0 && n > 1) begin
            offer(CMD_PATTERN, 1'b0, 1'($urandom_range(1)), pick_pattern_char());
         end
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int target);
      char_q_type pat;
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      while (items_sent < target) begin
         if ($urandom_range(9) == 0) begin
            offer(wgm_cmd_type'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), CHAR_W'($urandom_range(255)));
         end else begin
            pat = make_pattern();
            offer_pattern(pat);
            repeat ($urandom_range(1, 4)) begin
               offer_text(text_for(pat), $urandom_range(9) == 0);
               // Text that keeps going past its last mark.
               if ($urandom_range(7) == 0) begin
                  offer(CMD_TEXT, 1'b0, 1'($urandom_range(1)), pick_letter());
               end
            end
         end
      end
      drain();
   endtask

   initial begin
      char_q_type long_pat;
      char_q_type long_txt;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      send_gap_pct = 0;
      recv_gap_pct = 0;
      holds_asked  = 0;
      holds_done   = 0;
      items_sent   = 0;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty pattern after reset, then text with no restart.
      offer(CMD_TEXT, 1'b1, 1'b1, 8'h61);
      offer(CMD_TEXT, 1'b0, 1'b1, 8'h62);
      // Extreme bytes with both wildcards.
      offer(CMD_PATTERN, 1'b1, 1'b0, 8'h00);
      offer(CMD_PATTERN, 1'b0, 1'b0, 8'hff);
      offer(CMD_PATTERN, 1'b0, 1'b0, WILD_ONE);
      offer(CMD_PATTERN, 1'b0, 1'b1, WILD_RUN);
      offer(CMD_TEXT, 1'b1, 1'b0, 8'h00);
      offer(CMD_TEXT, 1'b0, 1'b0, 8'hff);
      offer(CMD_TEXT, 1'b0, 1'b1, 8'h7a);
      offer(CMD_TEXT, 1'b0, 1'b1, 8'h71);
      offer(CMD_TEXT, 1'b1, 1'b1, 8'hff);
      // Leading stars with a stray last mark in the middle.
      offer(CMD_PATTERN, 1'b1, 1'b0, WILD_RUN);
      offer(CMD_PATTERN, 1'b0, 1'b1, WILD_RUN);
      offer(CMD_PATTERN, 1'b0, 1'b1, 8'h62);
      offer(CMD_TEXT, 1'b1, 1'b1, 8'h62);
      offer(CMD_TEXT, 1'b1, 1'b1, 8'h63);
      // The pattern grows while a text is in flight.
      offer(CMD_TEXT, 1'b1, 1'b0, 8'h78);
      offer(CMD_TEXT, 1'b0, 1'b0, 8'h62);
      offer(CMD_PATTERN, 1'b0, 1'b1, 8'h79);
      offer(CMD_TEXT, 1'b0, 1'b1, 8'h79);
      drain();

      // A pattern longer than the store, matched on its truncated part.
      for (int i = 0; i < MAX_PATTERN + 2; i++) begin
         long_pat.push_back(WILD_ONE);
      end
      repeat (MAX_PATTERN) long_txt.push_back(CHAR_W'($urandom_range(255)));
      offer_pattern(long_pat);
      offer_text(long_txt, 1'b0);
      offer_text(text_for(long_pat), 1'b0);
      drain();

      run_phase(9, 59, ITEMS_PER_PHASE);
      run_phase(59, 9, 2 * ITEMS_PER_PHASE);

      // Results back up while the sender keeps offering short texts.
      offer(CMD_PATTERN, 1'b1, 1'b1, WILD_RUN);
      holds_asked++;
      repeat (40) offer(CMD_TEXT, 1'b1, 1'b1, pick_letter());
      run_phase(0, 0, 3 * ITEMS_PER_PHASE);

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/wgm_pkg.sv
sv/wgm_chan_if.sv
sv/wgm_cell.sv
sv/wgm_ctrl.sv
sv/wildcard_glob_matcher_core.sv
sv/wgm_checker.sv
bench/wgm_match_checker.sv
bench/tb_wildcard_glob_matcher_core.sv
